FILE: src/fpce_pkg.sv
`timescale 1ns / 1ps
// fpce_pkg: types, command codes, constants and helper functions shared by the
// flash programmer command engine. No dependencies.
package fpce_pkg;

  localparam logic [7:0] ACK_BYTE  = 8'h06;
  localparam logic [7:0] NAK_BYTE  = 8'h15;
  localparam logic [7:0] FILL_BYTE = 8'hff;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  localparam logic [7:0] CMD_NOP     = 8'h00;
  localparam logic [7:0] CMD_IFACE   = 8'h01;
  localparam logic [7:0] CMD_CMDMAP  = 8'h02;
  localparam logic [7:0] CMD_PGMNAME = 8'h03;
  localparam logic [7:0] CMD_SERBUF  = 8'h04;
  localparam logic [7:0] CMD_BUSTYPE = 8'h05;
  localparam logic [7:0] CMD_SYNCNOP = 8'h10;
  localparam logic [7:0] CMD_SETBUS  = 8'h12;
  localparam logic [7:0] CMD_SPIOP   = 8'h13;

  localparam logic [7:0] BUS_RESET     = 8'h08;
  localparam logic [7:0] VERSION_RESET = 8'h01;

  localparam int MAP_BYTES   = 4;
  localparam int MAP_ZEROS   = 28;
  localparam int NAME_BYTES  = 16;
  localparam int IDX_W       = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int SHIFT_W     = 24;
  localparam int LEN_EXT_W   = 32;

  typedef enum logic [2:0] {
    CFG_COMMAND_MAP,
    CFG_SUPPORTED_BUS,
    CFG_INTERFACE_VERSION,
    CFG_NAME_LOW,
    CFG_NAME_HIGH
  } cfg_index_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BUSARG,
    PH_LENGTHS,
    PH_WRITE,
    PH_READ
  } phase_t;

  typedef enum logic [1:0] {
    RK_ONE,
    RK_PAIR,
    RK_QUERY
  } resp_kind_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       host_valid;
    logic [7:0] host_byte;
    logic       spi_valid;
    logic [7:0] spi_byte;
    logic       chip_select;
    logic       protocol_error;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       host_valid;
    logic [7:0] host_byte;
    logic       spi_valid;
    logic [7:0] spi_byte;
    logic       chip_select;
    logic       protocol_error;
  } item_body_t;

  typedef struct packed {
    logic [31:0] command_map;
    logic [7:0]  supported_bus;
    logic [7:0]  interface_version;
    logic [63:0] name_low;
    logic [63:0] name_high;
  } cfg_regs_t;

  typedef struct packed {
    resp_kind_t kind;
    logic [7:0] cmd;
    item_body_t first;
    logic       second_spi;
    logic       second_cs;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } q_push_t;

  function automatic item_body_t blank_item(input logic cs);
    item_body_t r;
    r = '0;
    r.chip_select = cs;
    return r;
  endfunction

  function automatic item_body_t err_item(input logic cs);
    item_body_t r;
    r = blank_item(cs);
    r.protocol_error = 1'b1;
    return r;
  endfunction

  function automatic item_body_t host_item(input logic [7:0] b, input logic cs);
    item_body_t r;
    r = blank_item(cs);
    r.host_valid = 1'b1;
    r.host_byte  = b;
    return r;
  endfunction

  function automatic item_body_t spi_item(input logic [7:0] b, input logic cs);
    item_body_t r;
    r = blank_item(cs);
    r.spi_valid = 1'b1;
    r.spi_byte  = b;
    return r;
  endfunction

  // Number of result words for each query command, acknowledge included.
  function automatic logic [IDX_W-1:0] qry_count(input logic [7:0] cmd);
    logic [IDX_W-1:0] n;
    case (cmd)
      CMD_IFACE:   n = IDX_W'(3);
      CMD_CMDMAP:  n = IDX_W'(1 + MAP_BYTES + MAP_ZEROS);
      CMD_PGMNAME: n = IDX_W'(1 + NAME_BYTES);
      CMD_SERBUF:  n = IDX_W'(3);
      CMD_BUSTYPE: n = IDX_W'(2);
      CMD_SYNCNOP: n = IDX_W'(2);
      default:     n = IDX_W'(1);
    endcase
    return n;
  endfunction

endpackage

FILE: src/fpce_front.sv
`timescale 1ns / 1ps
// fpce_front: accepts input words, tracks the protocol phase and lengths, and
// pushes one response descriptor per word that has results. Uses fpce_pkg.
module fpce_front #(
  parameter int LENGTH_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fpce_pkg::in_item_t in_data,
  input  logic [7:0]         supported_bus,
  input  logic               q_full,
  output fpce_pkg::q_push_t  q_push
);
  import fpce_pkg::*;

  localparam logic [LEN_EXT_W-1:0] LEN_CAP = {LEN_EXT_W{1'b1}} >> (LEN_EXT_W - LENGTH_BITS);
  localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);
  localparam logic [2:0] WRITE_LEN_LAST = 3'd2;
  localparam logic [2:0] READ_LEN_LAST  = 3'd5;

  phase_t                 phase_r, phase_nxt;
  logic [2:0]             arg_count_r, arg_count_nxt;
  logic [SHIFT_W-1:0]     shift_r, shift_nxt;
  logic [LENGTH_BITS-1:0] write_left_r, write_left_nxt;
  logic [LENGTH_BITS-1:0] read_left_r, read_left_nxt;
  logic                   pending_r, pending_nxt;
  logic                   select_r, select_nxt;

  logic                   accept;
  logic                   push;
  desc_t                  desc;
  logic [SHIFT_W-1:0]     shift_in;
  logic [LEN_EXT_W-1:0]   shift_ext;
  logic [LENGTH_BITS-1:0] len_clamped;
  logic                   read_nz;
  logic                   read_more;

  assign accept    = in_valid && !q_full;
  assign in_stall  = q_full;
  assign shift_in  = {in_data.data_byte, shift_r[SHIFT_W-1:8]};
  assign shift_ext = LEN_EXT_W'(shift_in);
  assign len_clamped = (shift_ext > LEN_CAP) ? LEN_CAP[LENGTH_BITS-1:0]
                                             : shift_ext[LENGTH_BITS-1:0];
  assign read_nz   = (len_clamped != '0);
  assign read_more = (read_left_r != LEN_ONE);

  always_comb begin
    phase_nxt      = phase_r;
    arg_count_nxt  = arg_count_r;
    shift_nxt      = shift_r;
    write_left_nxt = write_left_r;
    read_left_nxt  = read_left_r;
    pending_nxt    = pending_r;
    select_nxt     = select_r;
    push           = 1'b0;
    desc.kind       = RK_ONE;
    desc.cmd        = ZERO_BYTE;
    desc.first      = blank_item(select_r);
    desc.second_spi = 1'b0;
    desc.second_cs  = 1'b0;
    if (accept) begin
      if (in_data.opcode) begin
        if (!pending_r) begin
          push       = 1'b1;
          desc.first = err_item(select_r);
        end else if (phase_r == PH_WRITE) begin
          pending_nxt    = 1'b0;
          write_left_nxt = write_left_r - LEN_ONE;
          if (write_left_r == LEN_ONE) begin
            push            = 1'b1;
            desc.kind       = RK_PAIR;
            desc.first      = host_item(ACK_BYTE, 1'b1);
            desc.second_spi = (read_left_r != '0);
            desc.second_cs  = (read_left_r != '0);
            pending_nxt     = (read_left_r != '0);
            select_nxt      = (read_left_r != '0);
            phase_nxt       = (read_left_r != '0) ? PH_READ : PH_IDLE;
          end
        end else if (phase_r == PH_READ) begin
          push            = 1'b1;
          desc.kind       = RK_PAIR;
          desc.first      = host_item(in_data.data_byte, 1'b1);
          desc.second_spi = read_more;
          desc.second_cs  = read_more;
          read_left_nxt   = read_left_r - LEN_ONE;
          pending_nxt     = read_more;
          if (!read_more) begin
            phase_nxt  = PH_IDLE;
            select_nxt = 1'b0;
          end
        end else begin
          pending_nxt = 1'b0;
          push        = 1'b1;
          desc.first  = err_item(select_r);
        end
      end else begin
        case (phase_r)
          PH_BUSARG: begin
            phase_nxt  = PH_IDLE;
            push       = 1'b1;
            desc.first = host_item(((in_data.data_byte & ~supported_bus) == ZERO_BYTE) ?
                                   ACK_BYTE : NAK_BYTE, select_r);
          end
          PH_LENGTHS: begin
            shift_nxt     = shift_in;
            arg_count_nxt = arg_count_r + 3'd1;
            if (arg_count_r == WRITE_LEN_LAST) begin
              write_left_nxt = len_clamped;
              shift_nxt      = '0;
            end else if (arg_count_r == READ_LEN_LAST) begin
              read_left_nxt = len_clamped;
              shift_nxt     = '0;
              arg_count_nxt = '0;
              select_nxt    = 1'b1;
              push          = 1'b1;
              if (write_left_r != '0) begin
                phase_nxt  = PH_WRITE;
                desc.first = blank_item(1'b1);
              end else begin
                desc.kind       = RK_PAIR;
                desc.first      = host_item(ACK_BYTE, 1'b1);
                desc.second_spi = read_nz;
                desc.second_cs  = read_nz;
                pending_nxt     = read_nz;
                select_nxt      = read_nz;
                phase_nxt       = read_nz ? PH_READ : PH_IDLE;
              end
            end
          end
          PH_WRITE: begin
            push = 1'b1;
            if (pending_r) begin
              desc.first = err_item(select_r);
            end else begin
              pending_nxt = 1'b1;
              desc.first  = spi_item(in_data.data_byte, select_r);
            end
          end
          PH_READ: begin
            push       = 1'b1;
            desc.first = err_item(select_r);
          end
          default: begin
            phase_nxt = PH_IDLE;
            case (in_data.data_byte)
              CMD_NOP, CMD_IFACE, CMD_CMDMAP, CMD_PGMNAME, CMD_SERBUF, CMD_BUSTYPE,
              CMD_SYNCNOP: begin
                push      = 1'b1;
                desc.kind = RK_QUERY;
                desc.cmd  = in_data.data_byte;
              end
              CMD_SETBUS: begin
                phase_nxt = PH_BUSARG;
              end
              CMD_SPIOP: begin
                phase_nxt     = PH_LENGTHS;
                arg_count_nxt = '0;
                shift_nxt     = '0;
              end
              default: begin
                if (in_data.data_byte > CMD_SPIOP) begin
                  push       = 1'b1;
                  desc.first = err_item(select_r);
                end
              end
            endcase
          end
        endcase
      end
    end
  end

  assign q_push.valid = push;
  assign q_push.desc  = desc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      arg_count_r  <= '0;
      shift_r      <= '0;
      write_left_r <= '0;
      read_left_r  <= '0;
      pending_r    <= 1'b0;
      select_r     <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      arg_count_r  <= arg_count_nxt;
      shift_r      <= shift_nxt;
      write_left_r <= write_left_nxt;
      read_left_r  <= read_left_nxt;
      pending_r    <= pending_nxt;
      select_r     <= select_nxt;
    end
  end

  a_pending_in_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> (phase_r == PH_WRITE || phase_r == PH_READ))
    else $error("exchange pending outside a transfer phase");

  a_selected_in_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WRITE || phase_r == PH_READ) |-> select_r)
    else $error("chip deselected during a transfer phase");

  a_read_always_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_READ) |-> pending_r)
    else $error("read phase without an exchange in flight");

endmodule

FILE: src/fpce_queue.sv
`timescale 1ns / 1ps
// fpce_queue: short first-in first-out queue of response descriptors between
// the front and back ends. Uses fpce_pkg.
module fpce_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  fpce_pkg::q_push_t push,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output fpce_pkg::desc_t   head
);
  import fpce_pkg::*;

  desc_t             entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full  = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push.valid ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid && !pop) begin
      count_nxt = count_r + (QPTR_W + 1)'(1);
    end else if (pop && !push.valid) begin
      count_nxt = count_r - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries_r[wr_ptr_r] <= push.desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !full)
    else $error("descriptor pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("descriptor popped from an empty queue");

endmodule

FILE: src/fpce_back.sv
`timescale 1ns / 1ps
// fpce_back: expands each response descriptor into result words, one per
// cycle while out_stall is low, into a registered output stage. Uses fpce_pkg.
module fpce_back (
  input  logic                clk,
  input  logic                rst_n,
  input  fpce_pkg::cfg_regs_t cfg,
  input  fpce_pkg::desc_t     head,
  input  logic                q_empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output fpce_pkg::out_item_t out_data
);
  import fpce_pkg::*;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             ended_r, ended_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic [IDX_W-1:0] count;
  logic [IDX_W-1:0] sel;
  logic             is_last;
  logic             advance;
  logic [127:0]     name_all;
  logic [7:0]       map_raw;
  logic [7:0]       name_raw;
  logic             name_zero;
  logic [7:0]       qry_byte;
  item_body_t       body;

  assign sel      = idx_r - IDX_W'(1);
  assign name_all = {cfg.name_high, cfg.name_low};
  assign map_raw  = cfg.command_map[{sel[1:0], 3'b000} +: 8];
  assign name_raw = name_all[{sel[3:0], 3'b000} +: 8];
  assign name_zero = (head.kind == RK_QUERY) && (head.cmd == CMD_PGMNAME) &&
                     (idx_r != '0) && (name_raw == ZERO_BYTE);
  assign is_last  = (idx_r == count - IDX_W'(1));
  assign advance  = !q_empty && (!out_valid_r || !out_stall);

  always_comb begin
    case (head.kind)
      RK_ONE:   count = IDX_W'(1);
      RK_PAIR:  count = IDX_W'(2);
      RK_QUERY: count = qry_count(head.cmd);
      default:  count = IDX_W'(1);
    endcase
  end

  always_comb begin
    qry_byte = ZERO_BYTE;
    if (idx_r == '0) begin
      qry_byte = (head.cmd == CMD_SYNCNOP) ? NAK_BYTE : ACK_BYTE;
    end else begin
      case (head.cmd)
        CMD_IFACE:   qry_byte = (idx_r == IDX_W'(1)) ? cfg.interface_version : ZERO_BYTE;
        CMD_CMDMAP:  qry_byte = (sel < IDX_W'(MAP_BYTES)) ? map_raw : ZERO_BYTE;
        CMD_PGMNAME: qry_byte = (ended_r || name_raw == ZERO_BYTE) ? ZERO_BYTE : name_raw;
        CMD_SERBUF:  qry_byte = FILL_BYTE;
        CMD_BUSTYPE: qry_byte = cfg.supported_bus;
        CMD_SYNCNOP: qry_byte = ACK_BYTE;
        default:     qry_byte = ZERO_BYTE;
      endcase
    end
  end

  always_comb begin
    case (head.kind)
      RK_PAIR: begin
        if (idx_r == '0) begin
          body = head.first;
        end else if (head.second_spi) begin
          body = spi_item(ZERO_BYTE, head.second_cs);
        end else begin
          body = blank_item(head.second_cs);
        end
      end
      RK_QUERY: body = host_item(qry_byte, head.first.chip_select);
      default:  body = head.first;
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    ended_nxt     = ended_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    if (advance) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.host_valid     = body.host_valid;
      out_data_nxt.host_byte      = body.host_byte;
      out_data_nxt.spi_valid      = body.spi_valid;
      out_data_nxt.spi_byte       = body.spi_byte;
      out_data_nxt.chip_select    = body.chip_select;
      out_data_nxt.protocol_error = body.protocol_error;
      out_data_nxt.last           = is_last;
      if (is_last) begin
        idx_nxt   = '0;
        ended_nxt = 1'b0;
        pop       = 1'b1;
      end else begin
        idx_nxt   = idx_r + IDX_W'(1);
        ended_nxt = ended_r || name_zero;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      ended_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      ended_r     <= ended_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: src/flash_programmer_command_engine_core.sv
`timescale 1ns / 1ps
// Programmer protocol engine with an SPI bridge: front end, descriptor queue,
// back end and configuration registers. Uses fpce_pkg and the fpce_* modules.
//
// The engine takes one input word per clock cycle whenever its four-entry
// descriptor queue has room, and the back end delivers one result word per
// cycle through a registered output stage while out_stall is low. The back
// end sets the sustained rate: a query emits its whole answer one word a
// cycle (33 result words for the command map query, 17 for the name query),
// and input is held off only when the queue fills behind such answers. Stub
// commands produce no result word. Configuration registers are writeable in
// any cycle; no clearing pass follows reset.
module flash_programmer_command_engine_core #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fpce_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fpce_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import fpce_pkg::*;

  cfg_regs_t cfg_r, cfg_nxt;
  q_push_t   q_push;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  desc_t     q_head;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COMMAND_MAP:       cfg_nxt.command_map       = cfg_data[31:0];
        CFG_SUPPORTED_BUS:     cfg_nxt.supported_bus     = cfg_data[7:0];
        CFG_INTERFACE_VERSION: cfg_nxt.interface_version = cfg_data[7:0];
        CFG_NAME_LOW:          cfg_nxt.name_low          = cfg_data;
        CFG_NAME_HIGH:         cfg_nxt.name_high         = cfg_data;
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.command_map       <= '0;
      cfg_r.supported_bus     <= BUS_RESET;
      cfg_r.interface_version <= VERSION_RESET;
      cfg_r.name_low          <= '0;
      cfg_r.name_high         <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fpce_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .supported_bus (cfg_r.supported_bus),
    .q_full        (q_full),
    .q_push        (q_push)
  );

  fpce_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head)
  );

  fpce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (q_head),
    .q_empty   (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
